// ===== design/rult_pkg.sv =====
// Package: shared types, operation and error codes for the unstable log tracker.
`default_nettype none
package rult_pkg;
    localparam int unsigned RingDepthDefault = 1024;
    localparam int unsigned QueueDepth = 2;

    localparam logic [2:0] FUNC_APPEND   = 3'd0;
    localparam logic [2:0] FUNC_QUERY    = 3'd1;
    localparam logic [2:0] FUNC_ACCEPT   = 3'd2;
    localparam logic [2:0] FUNC_STABLE   = 3'd3;
    localparam logic [2:0] FUNC_STBL_SNP = 3'd4;
    localparam logic [2:0] FUNC_RESTORE  = 3'd5;

    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_GAP  = 2'd1;
    localparam logic [1:0] ERR_FULL = 2'd2;

    typedef struct packed {
        logic [2:0]  func;
        logic [63:0] entry_index;
        logic [63:0] entry_term;
    } t_cmd;

    typedef struct packed {
        logic        term_found;
        logic [63:0] term_value;
        logic        first_valid;
        logic [63:0] first_index;
        logic        last_valid;
        logic [63:0] last_index;
        logic [63:0] progress_index;
        logic        snapshot_pending;
        logic        applied;
        logic [1:0]  error_code;
    } t_rsp;
endpackage
`default_nettype wire

// ===== design/rult_if.sv =====
// Interfaces: valid/ready channels for commands and results.
`default_nettype none
interface rult_cmd_if;
    logic          valid;
    logic          ready;
    rult_pkg::t_cmd payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface rult_rsp_if;
    logic          valid;
    logic          ready;
    rult_pkg::t_rsp payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== design/rult_front.sv =====
// Front: accepts command beats into a short queue.
`default_nettype none
module rult_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    rult_cmd_if.sink            i_cmd,
    output rult_pkg::t_cmd      o_head,
    output logic                o_head_valid,
    input  wire logic           i_pop
);
    import rult_pkg::*;
    t_cmd       r_q [QueueDepth];
    logic [0:0] r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push;

    assign i_cmd.ready  = (r_cnt != 2'(QueueDepth));
    assign push         = i_cmd.valid && i_cmd.ready;
    assign o_head_valid = (r_cnt != 2'd0);
    assign o_head       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_cmd.payload;
        end
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (i_pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + 2'(push) - 2'(i_pop);
        end
    end

`ifndef SYNTH
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_head_valid) else $error("pop from empty queue");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'(QueueDepth)) else $error("queue overfill");
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'(QueueDepth) && !i_pop) |=> r_cnt == 2'(QueueDepth))
        else $error("full queue lost an entry");
`endif
endmodule
`default_nettype wire

// ===== design/rult_back.sv =====
// Back: executes commands in two phases (ring read, then update) and holds the result.
`default_nettype none
module rult_back #(
    parameter int unsigned RING_DEPTH = rult_pkg::RingDepthDefault
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  rult_pkg::t_cmd      i_head,
    input  wire logic           i_head_valid,
    output logic                o_pop,
    rult_rsp_if.source          o_rsp
);
    import rult_pkg::*;
    localparam int unsigned AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int unsigned CW = $clog2(RING_DEPTH + 1);

    logic [63:0] r_ring [RING_DEPTH];
    logic [63:0] r_rd;
    logic [63:0] r_base, r_hand, r_sidx, r_sterm;
    logic [CW-1:0] r_cnt;
    logic [AW-1:0] r_bslot;   // ring slot of the base entry
    logic r_sheld, r_sbusy;
    logic r_rdph;   // ring read issued, execute once the result register is free
    logic r_ov;
    t_rsp r_rsp;

    logic [63:0] n_base, n_hand, n_sidx, n_sterm, d, lastv;
    logic [CW-1:0] n_cnt;
    logic [AW-1:0] n_bslot, wslot, slot;
    logic [AW:0] ssum;
    logic n_sheld, n_sbusy, wr, found, applied, held, go;
    logic [63:0] tval;
    logic [1:0] err;
    t_rsp rsp;

    assign d    = i_head.entry_index - r_base;
    // slot of a held entry or of the next one: base slot plus offset, wrapped
    assign ssum = {1'b0, r_bslot} + {1'b0, d[AW-1:0]};
    assign slot = (ssum >= (AW+1)'(RING_DEPTH)) ? AW'(ssum - (AW+1)'(RING_DEPTH))
                                                : ssum[AW-1:0];
    assign held = (i_head.entry_index >= r_base) && (d < 64'(r_cnt));
    assign go   = r_rdph && (!r_ov || o_rsp.ready);
    assign o_pop = go;

    always_comb begin
        n_base = r_base; n_hand = r_hand; n_cnt = r_cnt; n_sheld = r_sheld;
        n_sbusy = r_sbusy; n_sidx = r_sidx; n_sterm = r_sterm;
        n_bslot = r_bslot; wslot = slot;
        wr = 1'b0; found = 1'b0; tval = '0; applied = 1'b0; err = ERR_NONE;
        unique case (i_head.func)
            FUNC_APPEND: begin
                priority if (i_head.entry_index >= r_base && d == 64'(r_cnt)) begin
                    if (r_cnt == CW'(RING_DEPTH)) begin
                        err = ERR_FULL;
                    end else begin
                        wr = 1'b1; n_cnt = r_cnt + 1'b1; applied = 1'b1;
                    end
                end else if (i_head.entry_index <= r_base) begin
                    wr = 1'b1; n_base = i_head.entry_index; n_hand = i_head.entry_index;
                    n_cnt = CW'(1); applied = 1'b1;
                    wslot = '0; n_bslot = '0;
                end else if (d < 64'(r_cnt)) begin
                    wr = 1'b1; n_cnt = CW'(d) + 1'b1; applied = 1'b1;
                    if (i_head.entry_index < r_hand) n_hand = i_head.entry_index;
                end else begin
                    err = ERR_GAP;
                end
            end
            FUNC_QUERY: begin
                if (i_head.entry_index < r_base) begin
                    if (r_sheld && r_sidx == i_head.entry_index) begin
                        found = 1'b1; tval = r_sterm;
                    end
                end else if (held) begin
                    found = 1'b1; tval = r_rd;
                end
            end
            FUNC_ACCEPT: begin
                if (r_cnt != '0) begin
                    n_hand = r_base + 64'(r_cnt); applied = 1'b1;
                end
                if (r_sheld) begin
                    n_sbusy = 1'b1; applied = 1'b1;
                end
            end
            FUNC_STABLE: begin
                if (held && r_rd == i_head.entry_term) begin
                    n_cnt = r_cnt - CW'(d) - 1'b1;
                    n_base = i_head.entry_index + 64'd1;
                    n_bslot = (slot == AW'(RING_DEPTH - 1)) ? '0 : slot + 1'b1;
                    if (r_hand < n_base) n_hand = n_base;
                    applied = 1'b1;
                end
            end
            FUNC_STBL_SNP: begin
                if (r_sheld && r_sidx == i_head.entry_index) begin
                    n_sheld = 1'b0; n_sbusy = 1'b0; n_sidx = '0; n_sterm = '0;
                    applied = 1'b1;
                end
            end
            FUNC_RESTORE: begin
                n_base = i_head.entry_index + 64'd1; n_hand = n_base; n_cnt = '0;
                n_sheld = 1'b1; n_sidx = i_head.entry_index; n_bslot = '0;
                n_sterm = i_head.entry_term; n_sbusy = 1'b0; applied = 1'b1;
            end
            default: ;
        endcase
        lastv = n_base + 64'(n_cnt) - 64'd1;
        rsp.term_found       = found;
        rsp.term_value       = tval;
        rsp.first_valid      = n_sheld;
        rsp.first_index      = n_sheld ? n_sidx + 64'd1 : '0;
        rsp.last_valid       = (n_cnt != '0) || n_sheld;
        rsp.last_index       = (n_cnt != '0) ? lastv : (n_sheld ? n_sidx : '0);
        rsp.progress_index   = n_hand;
        rsp.snapshot_pending = n_sheld && !n_sbusy;
        rsp.applied          = applied;
        rsp.error_code       = err;
    end

    always_ff @(posedge i_clk) begin
        r_rd <= r_ring[slot];
        if (go && wr) r_ring[wslot] <= i_head.entry_term;
        if (go) begin
            r_rsp <= rsp;
        end
        if (!i_rst_n) begin
            r_base <= '0; r_hand <= '0; r_cnt <= '0; r_sheld <= 1'b0;
            r_sbusy <= 1'b0; r_sidx <= '0; r_sterm <= '0; r_rdph <= 1'b0;
            r_ov <= 1'b0; r_bslot <= '0;
        end else begin
            if (go) begin
                r_base <= n_base; r_hand <= n_hand; r_cnt <= n_cnt;
                r_sheld <= n_sheld; r_sbusy <= n_sbusy; r_sidx <= n_sidx;
                r_sterm <= n_sterm; r_bslot <= n_bslot;
            end
            r_rdph <= i_head_valid && !go && !r_rdph ? 1'b1 : (r_rdph && !go);
            if (go) r_ov <= 1'b1;
            else if (o_rsp.ready) r_ov <= 1'b0;
        end
    end

    assign o_rsp.valid   = r_ov;
    assign o_rsp.payload = r_rsp;

`ifndef SYNTH
    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(RING_DEPTH)) else $error("held count beyond ring");
    a_busy_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sbusy |-> r_sheld) else $error("busy snapshot not held");
    a_go_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        go |=> !r_rdph) else $error("read phase not restarted");
    a_hand_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (go && i_head.func == FUNC_RESTORE) |=> r_hand == r_base)
        else $error("restore left progress off base");
`endif
endmodule
`default_nettype wire

// ===== design/raft_unstable_log_tracker_unit.sv =====
// Top level: unstable log tracker, queue front and execute back.
`default_nettype none
// Tracks the unstable tail of a consensus log: entry terms in a ring of
// RING_DEPTH slots, plus base, count, progress index and one pending
// snapshot. Held entries sit in consecutive slots (wrapping) starting at a
// base slot that moves with the base index; a reset-append or a restore
// starts again at slot zero. One command beat yields one result beat. Each
// command passes two phases in the back end: one reads the ring slot, then
// the other updates state and registers the result once the output register
// is free; a new command starts only after that. A two-entry queue in front
// keeps taking commands while a result waits on the output register. No
// clearing pass after reset: only written ring slots are ever used.
module raft_unstable_log_tracker_unit #(
    parameter int unsigned RING_DEPTH = rult_pkg::RingDepthDefault
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    rult_cmd_if.sink  i_cmd,
    rult_rsp_if.source o_rsp
);
    import rult_pkg::*;
    t_cmd head;
    logic head_valid, pop;

    rult_front u_front (
        .i_clk, .i_rst_n, .i_cmd,
        .o_head(head), .o_head_valid(head_valid), .i_pop(pop)
    );

    rult_back #(.RING_DEPTH(RING_DEPTH)) u_back (
        .i_clk, .i_rst_n, .i_head(head), .i_head_valid(head_valid),
        .o_pop(pop), .o_rsp
    );
endmodule
`default_nettype wire
